>>> hdl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

	// decode modes
	localparam logic [3:0] MODE_PLAIN    = 4'd0;
	localparam logic [3:0] MODE_ESC      = 4'd1;
	localparam logic [3:0] MODE_HEX      = 4'd2;
	localparam logic [3:0] MODE_HIGH     = 4'd3;
	localparam logic [3:0] MODE_HIGH_ESC = 4'd4;
	localparam logic [3:0] MODE_LOW_HEX  = 4'd5;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
	localparam logic [2:0] ERR_CONTROL      = 3'd2;
	localparam logic [2:0] ERR_TRAIL_BS     = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd4;
	localparam logic [2:0] ERR_BAD_U        = 3'd5;

	// most results one input item can cause
	localparam int RES_MAX = 6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       at_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
		logic       last;
	} out_item_t;

	// one result without its last flag
	typedef struct packed {
		logic [7:0] b;
		logic [1:0] kind;
		logic [2:0] code;
	} rec_t;

	// utf-8 encoding, byte 0 first
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} utf8_t;

endpackage

>>> hdl/jsu_chan_if.sv
`timescale 1ns / 1ps
interface jsu_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// the first result of an item is offered in the cycle after the item is accepted
// throughput, while result_ch is ready: one input item per cycle while each item
//   causes at most one result; the n results of an item leave the buffer one per cycle
// an item that causes no result leaves the buffer empty, but it is itself taken only
//   once the item before it hands over its last result
// reset: arst_n low clears the decode mode, hex state, held surrogate and result count
module json_string_unescape_utf8_unit (
	input logic       clk,
	input logic       arst_n,
	jsu_chan_if.sink   text_ch,
	jsu_chan_if.source result_ch
);

	// decode state
	logic [3:0]  mode_q;
	logic [1:0]  hcnt_q;
	logic [15:0] acc_q;
	logic [15:0] hi_q;

	// result buffer: results of one item, drained one per cycle while result_ch is ready
	jsu_pkg::rec_t buf_s1 [jsu_pkg::RES_MAX];
	logic [2:0]    cnt_q;
	logic [2:0]    idx_q;

	logic in_fire;
	logic out_fire;
	logic out_last;

	// next-state and result list of the item at the input
	logic [3:0]    mode_d;
	logic [1:0]    hcnt_d;
	logic [15:0]   acc_d;
	logic [15:0]   hi_d;
	logic [2:0]    n_d;
	jsu_pkg::rec_t res_d [jsu_pkg::RES_MAX];

	// hex digit value, msb is the valid flag
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - "A" + 8'd10)};
		return r;
	endfunction

	function automatic jsu_pkg::utf8_t utf8_enc(input logic [20:0] cp);
		jsu_pkg::utf8_t u;
		u = '0;
		if (cp < 21'h80) begin
			u.len  = 3'd1;
			u.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			u.len  = 3'd2;
			u.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			u.b[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp < 21'h10000) begin
			u.len  = 3'd3;
			u.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			u.b[1] = 8'h80 | {2'b00, cp[11:6]};
			u.b[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			u.len  = 3'd4;
			u.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
			u.b[1] = 8'h80 | {2'b00, cp[17:12]};
			u.b[2] = 8'h80 | {2'b00, cp[11:6]};
			u.b[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return u;
	endfunction

	// decode: up to three parts in order
	//   a: held high surrogate flushed alone (three bytes)
	//   b: one code point as utf-8
	//   c: one single result (data, close or error)
	always_comb begin
		logic [7:0]     b;
		logic           at_end;
		logic [4:0]     hv;
		logic [15:0]    acc_new;
		logic           a_en;
		logic           c_en;
		logic           b_en;
		jsu_pkg::utf8_t ua;
		jsu_pkg::utf8_t ub;
		logic [20:0]    cp_b;
		jsu_pkg::rec_t  rc;
		logic [2:0]     na;
		logic [2:0]     nab;
		logic [2:0]     j;
		logic           run_plain;
		logic           run_esc;
		logic           run_cp;
		logic [15:0]    cp_first;

		b       = text_ch.payload.in_byte;
		at_end  = text_ch.payload.at_end;
		hv      = hex_value(b);
		acc_new = {acc_q[11:0], hv[3:0]};

		mode_d = mode_q;
		hcnt_d = hcnt_q;
		acc_d  = acc_q;
		hi_d   = hi_q;

		a_en      = 1'b0;
		b_en      = 1'b0;
		c_en      = 1'b0;
		cp_b      = '0;
		rc        = '0;
		run_plain = 1'b0;
		run_esc   = 1'b0;
		run_cp    = 1'b0;
		cp_first  = acc_new;

		case (mode_q)
			jsu_pkg::MODE_ESC: begin
				run_esc = 1'b1;
			end
			jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
				if (at_end || !hv[4]) begin
					c_en    = 1'b1;
					rc.kind = jsu_pkg::KIND_ERROR;
					rc.code = jsu_pkg::ERR_BAD_U;
					mode_d  = jsu_pkg::MODE_PLAIN;
				end else begin
					acc_d = acc_new;
					if (hcnt_q == 2'd3) begin
						hcnt_d = 2'd0;
						if (mode_q == jsu_pkg::MODE_HEX) begin
							run_cp = 1'b1;
						end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
							// surrogate pair: hi and lo each carry ten payload bits
							b_en   = 1'b1;
							cp_b   = 21'h10000 + {1'b0, hi_q[9:0], acc_new[9:0]};
							mode_d = jsu_pkg::MODE_PLAIN;
						end else begin
							// second escape is not a low surrogate
							a_en   = 1'b1;
							run_cp = 1'b1;
						end
					end else begin
						hcnt_d = hcnt_q + 2'd1;
					end
				end
			end
			jsu_pkg::MODE_HIGH: begin
				if (!at_end && b == "\\") begin
					mode_d = jsu_pkg::MODE_HIGH_ESC;
				end else begin
					a_en      = 1'b1;
					run_plain = 1'b1;
				end
			end
			jsu_pkg::MODE_HIGH_ESC: begin
				if (!at_end && b == "u") begin
					hcnt_d = 2'd0;
					acc_d  = 16'd0;
					mode_d = jsu_pkg::MODE_LOW_HEX;
				end else begin
					a_en    = 1'b1;
					run_esc = 1'b1;
				end
			end
			default: begin
				run_plain = 1'b1;
			end
		endcase

		// complete code point from a first escape
		if (run_cp) begin
			if (cp_first >= 16'hD800 && cp_first <= 16'hDBFF) begin
				hi_d   = cp_first;
				mode_d = jsu_pkg::MODE_HIGH;
			end else begin
				b_en   = 1'b1;
				cp_b   = {5'd0, cp_first};
				mode_d = jsu_pkg::MODE_PLAIN;
			end
		end

		if (run_plain) begin
			mode_d = jsu_pkg::MODE_PLAIN;
			if (at_end) begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_ERROR;
				rc.code = jsu_pkg::ERR_UNTERMINATED;
			end else if (b == "\"") begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_CLOSE;
			end else if (b == "\\") begin
				mode_d = jsu_pkg::MODE_ESC;
			end else if (b < 8'h20) begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_ERROR;
				rc.code = jsu_pkg::ERR_CONTROL;
			end else begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_DATA;
				rc.b    = b;
			end
		end

		if (run_esc) begin
			mode_d = jsu_pkg::MODE_PLAIN;
			if (at_end) begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_ERROR;
				rc.code = jsu_pkg::ERR_TRAIL_BS;
			end else begin
				c_en    = 1'b1;
				rc.kind = jsu_pkg::KIND_DATA;
				case (b)
					"\"": rc.b = 8'h22;
					"\\": rc.b = 8'h5C;
					"/":  rc.b = 8'h2F;
					"b":  rc.b = 8'h08;
					"f":  rc.b = 8'h0C;
					"n":  rc.b = 8'h0A;
					"r":  rc.b = 8'h0D;
					"t":  rc.b = 8'h09;
					"u": begin
						c_en   = 1'b0;
						hcnt_d = 2'd0;
						acc_d  = 16'd0;
						mode_d = jsu_pkg::MODE_HEX;
					end
					default: begin
						rc.kind = jsu_pkg::KIND_ERROR;
						rc.code = jsu_pkg::ERR_UNKNOWN_ESC;
					end
				endcase
			end
		end

		// assemble the result list
		ua  = utf8_enc({5'd0, hi_q});
		ub  = utf8_enc(cp_b);
		na  = a_en ? 3'd3 : 3'd0;
		nab = na + (b_en ? ub.len : 3'd0);
		n_d = nab + (c_en ? 3'd1 : 3'd0);
		for (int i = 0; i < jsu_pkg::RES_MAX; i++) begin
			j = 3'(i) - na;
			if (3'(i) < na) begin
				res_d[i] = '{b: ua.b[2'(i)], kind: jsu_pkg::KIND_DATA,
					code: jsu_pkg::ERR_NONE};
			end else if (3'(i) < nab) begin
				res_d[i] = '{b: ub.b[j[1:0]], kind: jsu_pkg::KIND_DATA,
					code: jsu_pkg::ERR_NONE};
			end else begin
				res_d[i] = rc;
			end
		end
	end

	// output side: one result per cycle from the buffer while result_ch is ready
	assign out_last          = (idx_q == cnt_q - 3'd1);
	assign result_ch.valid   = (cnt_q != 3'd0);
	assign result_ch.payload = '{out_byte: buf_s1[idx_q].b, kind: buf_s1[idx_q].kind,
		error_code: buf_s1[idx_q].code, last: out_last};
	assign out_fire          = result_ch.valid && result_ch.ready;

	// a new item is taken once the buffer is empty or hands over its last result now
	assign text_ch.ready = (cnt_q == 3'd0) || (out_fire && out_last);
	assign in_fire       = text_ch.valid && text_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_PLAIN;
			hcnt_q <= 2'd0;
			acc_q  <= 16'd0;
			hi_q   <= 16'd0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			hcnt_q <= hcnt_d;
			acc_q  <= acc_d;
			hi_q   <= hi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else if (in_fire) begin
			// buffer is free here, so the new list simply replaces it
			cnt_q <= n_d;
			idx_q <= 3'd0;
		end else if (out_fire) begin
			if (out_last) begin
				cnt_q <= 3'd0;
				idx_q <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// payload of the buffer, no reset
	always_ff @(posedge clk) begin
		if (in_fire && n_d != 3'd0) begin
			for (int i = 0; i < jsu_pkg::RES_MAX; i++) begin
				buf_s1[i] <= res_d[i];
			end
		end
	end

	// read pointer stays inside the loaded list
	a_idx_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (idx_q < cnt_q))
		else $error("result index beyond list");

	// an item with results is offered on the next cycle
	a_offer_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && n_d != 3'd0) |=> result_ch.valid)
		else $error("results of accepted item not offered");

	// no item is taken over a list that is still draining
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (!result_ch.valid || (result_ch.ready && out_last)))
		else $error("item accepted over pending results");

	// list never holds more than the most results of one item
	a_list_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(jsu_pkg::RES_MAX))
		else $error("result list too long");

endmodule
